FILE: hw/rtl/pwfp_pkg.sv
package pwfp_pkg;

  localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNC,
    ST_UNKNOWN,
    ST_OVERLONG
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] field_number;
    logic [2:0]  wtype;
    logic [63:0] value;
    status_t     status;
    logic        message_end;
  } res_t;

endpackage

FILE: hw/rtl/pwfp_if.sv
interface pwfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] field_number;
  logic [2:0]  wtype;
  logic [63:0] value;
  logic [1:0]  status;
  logic        message_end;

  modport source(output valid, output kind, output field_number, output wtype,
                 output value, output status, output message_end, input ready);
  modport sink(input valid, input kind, input field_number, input wtype,
               input value, input status, input message_end, output ready);
endinterface

FILE: hw/rtl/pwfp_core.sv
module pwfp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output logic           res_valid,
  output pwfp_pkg::res_t res
);

  pwfp_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [31:0] fn_r, fn_nxt;
  logic [2:0]  wt_r, wt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        halted_r, halted_nxt;

  logic [6:0]  sh7;
  logic [3:0]  cnt_inc;
  logic [63:0] ab_acc;
  logic        ab_done;
  logic        ab_over;
  logic [63:0] fx_acc;
  logic [63:0] rem_dec;
  logic [31:0] tag_fn;
  logic [2:0]  tag_wt;

  // varint byte absorb, bits beyond 64 dropped
  assign sh7     = 7'({3'b000, count_r}) * 7'd7;
  assign cnt_inc = count_r + 4'd1;
  assign ab_acc  = acc_r | ((sh7 < 7'd64) ? (64'(data_byte[6:0]) << sh7[5:0]) : 64'd0);
  assign ab_done = !data_byte[7];
  assign ab_over = data_byte[7] && (cnt_inc >= pwfp_pkg::MAX_VARINT_BYTES);
  assign tag_fn  = ab_acc[34:3];
  assign tag_wt  = ab_acc[2:0];

  // little-endian fixed byte placement
  assign fx_acc  = acc_r | (64'(data_byte) << {count_r[2:0], 3'b000});
  assign rem_dec = (rem_r != 64'd0) ? (rem_r - 64'd1) : rem_r;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    fn_nxt     = fn_r;
    wt_nxt     = wt_r;
    rem_nxt    = rem_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res.kind         = pwfp_pkg::KIND_FIELD;
    res.field_number = fn_r;
    res.wtype        = wt_r;
    res.value        = 64'd0;
    res.status       = pwfp_pkg::ST_OK;
    res.message_end  = last_byte;

    if (step && !halted_r) begin
      case (phase_r)
        pwfp_pkg::PH_VARINT: begin
          acc_nxt   = ab_acc;
          count_nxt = cnt_inc;
          if (ab_done) begin
            res_valid = 1'b1;
            res.value = ab_acc;
            phase_nxt = pwfp_pkg::PH_TAG;
            acc_nxt   = 64'd0;
            count_nxt = 4'd0;
          end else if (ab_over) begin
            res_valid  = 1'b1;
            res.value  = ab_acc;
            res.status = pwfp_pkg::ST_OVERLONG;
            halted_nxt = 1'b1;
          end else if (last_byte) begin
            res_valid  = 1'b1;
            res.status = pwfp_pkg::ST_TRUNC;
          end
        end
        pwfp_pkg::PH_FIXED: begin
          acc_nxt   = fx_acc;
          count_nxt = cnt_inc;
          rem_nxt   = rem_dec;
          if (rem_dec == 64'd0) begin
            res_valid = 1'b1;
            res.value = fx_acc;
            phase_nxt = pwfp_pkg::PH_TAG;
            acc_nxt   = 64'd0;
            count_nxt = 4'd0;
          end else if (last_byte) begin
            res_valid  = 1'b1;
            res.status = pwfp_pkg::ST_TRUNC;
          end
        end
        pwfp_pkg::PH_LENGTH: begin
          acc_nxt   = ab_acc;
          count_nxt = cnt_inc;
          res.wtype = pwfp_pkg::WT_LEN;
          if (ab_done) begin
            res_valid  = 1'b1;
            res.value  = ab_acc;
            res.status = (ab_acc != 64'd0 && last_byte) ? pwfp_pkg::ST_TRUNC
                                                        : pwfp_pkg::ST_OK;
            acc_nxt    = 64'd0;
            count_nxt  = 4'd0;
            if (ab_acc == 64'd0) begin
              phase_nxt = pwfp_pkg::PH_TAG;
            end else begin
              phase_nxt = pwfp_pkg::PH_PAYLOAD;
              rem_nxt   = ab_acc;
            end
          end else if (ab_over) begin
            res_valid  = 1'b1;
            res.value  = ab_acc;
            res.status = pwfp_pkg::ST_OVERLONG;
            halted_nxt = 1'b1;
          end else if (last_byte) begin
            res_valid  = 1'b1;
            res.status = pwfp_pkg::ST_TRUNC;
          end
        end
        pwfp_pkg::PH_PAYLOAD: begin
          rem_nxt    = rem_dec;
          res_valid  = 1'b1;
          res.kind   = pwfp_pkg::KIND_PAYLOAD;
          res.wtype  = pwfp_pkg::WT_LEN;
          res.value  = 64'(data_byte);
          res.status = (rem_dec != 64'd0 && last_byte) ? pwfp_pkg::ST_TRUNC
                                                       : pwfp_pkg::ST_OK;
          if (rem_dec == 64'd0) begin
            phase_nxt = pwfp_pkg::PH_TAG;
          end
        end
        default: begin
          acc_nxt          = ab_acc;
          count_nxt        = cnt_inc;
          res.field_number = 32'd0;
          res.wtype        = 3'd0;
          if (ab_done) begin
            res.field_number = tag_fn;
            res.wtype        = tag_wt;
            if (!(tag_wt inside {pwfp_pkg::WT_VARINT, pwfp_pkg::WT_FIXED64,
                                 pwfp_pkg::WT_LEN, pwfp_pkg::WT_FIXED32})) begin
              res_valid  = 1'b1;
              res.status = pwfp_pkg::ST_UNKNOWN;
              halted_nxt = 1'b1;
            end else if (last_byte) begin
              res_valid  = 1'b1;
              res.status = pwfp_pkg::ST_TRUNC;
            end else begin
              fn_nxt    = tag_fn;
              wt_nxt    = tag_wt;
              acc_nxt   = 64'd0;
              count_nxt = 4'd0;
              if (tag_wt == pwfp_pkg::WT_VARINT) begin
                phase_nxt = pwfp_pkg::PH_VARINT;
              end else if (tag_wt == pwfp_pkg::WT_LEN) begin
                phase_nxt = pwfp_pkg::PH_LENGTH;
              end else begin
                phase_nxt = pwfp_pkg::PH_FIXED;
                rem_nxt   = (tag_wt == pwfp_pkg::WT_FIXED64) ? 64'd8 : 64'd4;
              end
            end
          end else if (ab_over) begin
            res_valid  = 1'b1;
            res.value  = ab_acc;
            res.status = pwfp_pkg::ST_OVERLONG;
            halted_nxt = 1'b1;
          end else if (last_byte) begin
            res_valid  = 1'b1;
            res.status = pwfp_pkg::ST_TRUNC;
          end
        end
      endcase
    end

    // end of message returns everything to reset values
    if (step && last_byte) begin
      phase_nxt  = pwfp_pkg::PH_TAG;
      acc_nxt    = 64'd0;
      count_nxt  = 4'd0;
      fn_nxt     = 32'd0;
      wt_nxt     = 3'd0;
      rem_nxt    = 64'd0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pwfp_pkg::PH_TAG;
      acc_r    <= 64'd0;
      count_r  <= 4'd0;
      fn_r     <= 32'd0;
      wt_r     <= 3'd0;
      rem_r    <= 64'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      fn_r     <= fn_nxt;
      wt_r     <= wt_nxt;
      rem_r    <= rem_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

FILE: hw/rtl/protobuf_wire_field_parser.sv
// protobuf wire-format field parser
// in_ch: one message byte per request (data_byte) with last_byte on the final
// byte; a request is taken when valid and ready are both high.
// out_ch: one result per completed field (header/value), one per payload byte of a
// length-delimited field and one per error; tag and partial varint bytes give none.
// throughput: one byte per cycle sustained while out_ch is ready; set by the state
// update in the parser core between the input and the result register.
// path: a byte taken on in_ch waits in the input register and its result in the
// result register, which drives out_ch; a stall on out_ch holds both in place.
// when out_ch stalls, the input register still takes a byte if it is empty; after
// that in_ch.ready stays low until the result register drains.
// reset (rst_n low, synchronous) empties both registers and puts the parser
// in the expecting-tag phase; the block is ready in the cycle after release.
// the last byte of every message returns the parser to that same state, and
// a halted parser (unknown wire type, overlong varint) resumes there too.
module protobuf_wire_field_parser (
  input  logic              clk,
  input  logic              rst_n,
  pwfp_in_if.sink           in_ch,
  pwfp_out_if.source        out_ch
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       in_last_r;

  // result register
  logic           out_valid_r;
  pwfp_pkg::res_t out_res_r;

  logic           advance;
  logic           step;
  logic           res_valid;
  pwfp_pkg::res_t res;

  // result register can load when empty or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  pwfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.field_number = out_res_r.field_number;
  assign out_ch.wtype        = out_res_r.wtype;
  assign out_ch.value        = out_res_r.value;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.message_end  = out_res_r.message_end;

endmodule

FILE: test/protobuf_wire_field_parser_tb.sv
`timescale 1ns / 1ps

module protobuf_wire_field_parser_tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  // parsed bytes wanted over the whole run
  localparam int RANDOM_BYTES = 1050;
  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT  = 3000;
  // two-stage pipeline, so this wait covers any stray late result
  localparam int DRAIN_CYCLES = 8;
  // window of parsed bytes in which neither side idles
  localparam int BURST_START  = 500;
  localparam int BURST_END    = 700;

  // wire types the parser does not understand
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_BAD6   = 3'd6;
  localparam logic [2:0] WT_BAD7   = 3'd7;

  // outcome of taking one byte into a varint
  typedef enum int {VAR_MORE, VAR_DONE, VAR_OVERLONG} varint_step_t;

  // mirrors the parser state and queues the results each byte causes
  class field_result_board;
    pwfp_pkg::phase_t phase;
    logic [63:0]      acc;
    logic [3:0]       nbytes;
    logic [31:0]      held_fn;
    logic [2:0]       held_wt;
    logic [63:0]      remaining;
    bit               halted;
    pwfp_pkg::res_t   pending_fields[$];
    int unsigned      parsed_bytes;
    int unsigned      failures;
    int unsigned      reported;
    int unsigned      field_results;
    int unsigned      payload_results;
    int unsigned      status_count[4];

    function new();
      parsed_bytes = 0;
      failures = 0;
      reported = 0;
      field_results = 0;
      payload_results = 0;
      foreach (status_count[i]) status_count[i] = 0;
      restart();
    endfunction

    // state after reset and after every last byte
    function void restart();
      phase = pwfp_pkg::PH_TAG;
      acc = '0;
      nbytes = '0;
      held_fn = '0;
      held_wt = '0;
      remaining = '0;
      halted = 1'b0;
    endfunction

    function void push_result(logic kind, logic [31:0] fn, logic [2:0] wt, logic [63:0] val,
                              pwfp_pkg::status_t st, logic last);
      pwfp_pkg::res_t r;
      r.kind = kind;
      r.field_number = fn;
      r.wtype = wt;
      r.value = val;
      r.status = st;
      r.message_end = last;
      pending_fields.push_back(r);
    endfunction

    // groups past bit 63 are dropped, the count still advances
    function varint_step_t absorb(logic [7:0] b);
      int unsigned sh;
      sh = 7 * nbytes;
      if (sh < 64) acc = acc | ({57'd0, b[6:0]} << sh);
      nbytes = nbytes + 4'd1;
      if (!b[7]) return VAR_DONE;
      if (nbytes >= pwfp_pkg::MAX_VARINT_BYTES) return VAR_OVERLONG;
      return VAR_MORE;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      varint_step_t r;
      logic [31:0]  fn;
      logic [2:0]   wt;
      logic [63:0]  len;
      // a halted parser only waits for the end of the message
      if (halted) begin
        if (last) restart();
        return;
      end
      parsed_bytes++;
      case (phase)
        pwfp_pkg::PH_VARINT: begin
          r = absorb(b);
          if (r == VAR_OVERLONG) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, held_wt, acc, pwfp_pkg::ST_OVERLONG,
                        last);
            halted = 1'b1;
          end else if (r == VAR_DONE) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, held_wt, acc, pwfp_pkg::ST_OK, last);
            phase = pwfp_pkg::PH_TAG;
            acc = '0;
            nbytes = '0;
          end else if (last) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, held_wt, '0, pwfp_pkg::ST_TRUNC, 1'b1);
          end
        end
        pwfp_pkg::PH_FIXED: begin
          // little-endian raw word, byte count wraps at four bits
          acc = acc | ({56'd0, b} << (8 * nbytes[2:0]));
          nbytes = nbytes + 4'd1;
          if (remaining != 0) remaining = remaining - 64'd1;
          if (remaining == 0) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, held_wt, acc, pwfp_pkg::ST_OK, last);
            phase = pwfp_pkg::PH_TAG;
            acc = '0;
            nbytes = '0;
          end else if (last) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, held_wt, '0, pwfp_pkg::ST_TRUNC, 1'b1);
          end
        end
        pwfp_pkg::PH_LENGTH: begin
          r = absorb(b);
          if (r == VAR_OVERLONG) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, pwfp_pkg::WT_LEN, acc,
                        pwfp_pkg::ST_OVERLONG, last);
            halted = 1'b1;
          end else if (r == VAR_DONE) begin
            len = acc;
            push_result(pwfp_pkg::KIND_FIELD, held_fn, pwfp_pkg::WT_LEN, len,
                        (len != 0 && last) ? pwfp_pkg::ST_TRUNC : pwfp_pkg::ST_OK, last);
            acc = '0;
            nbytes = '0;
            if (len == 0) begin
              phase = pwfp_pkg::PH_TAG;
            end else begin
              phase = pwfp_pkg::PH_PAYLOAD;
              remaining = len;
            end
          end else if (last) begin
            push_result(pwfp_pkg::KIND_FIELD, held_fn, pwfp_pkg::WT_LEN, '0,
                        pwfp_pkg::ST_TRUNC, 1'b1);
          end
        end
        pwfp_pkg::PH_PAYLOAD: begin
          if (remaining != 0) remaining = remaining - 64'd1;
          push_result(pwfp_pkg::KIND_PAYLOAD, held_fn, pwfp_pkg::WT_LEN, {56'd0, b},
                      (remaining != 0 && last) ? pwfp_pkg::ST_TRUNC : pwfp_pkg::ST_OK, last);
          if (remaining == 0) phase = pwfp_pkg::PH_TAG;
        end
        default: begin
          r = absorb(b);
          if (r == VAR_OVERLONG) begin
            push_result(pwfp_pkg::KIND_FIELD, '0, '0, acc, pwfp_pkg::ST_OVERLONG, last);
            halted = 1'b1;
          end else if (r == VAR_DONE) begin
            fn = acc[34:3];
            wt = acc[2:0];
            if (wt != pwfp_pkg::WT_VARINT && wt != pwfp_pkg::WT_FIXED64 &&
                wt != pwfp_pkg::WT_LEN && wt != pwfp_pkg::WT_FIXED32) begin
              push_result(pwfp_pkg::KIND_FIELD, fn, wt, '0, pwfp_pkg::ST_UNKNOWN, last);
              halted = 1'b1;
            end else if (last) begin
              // tag closes the message
              push_result(pwfp_pkg::KIND_FIELD, fn, wt, '0, pwfp_pkg::ST_TRUNC, 1'b1);
            end else begin
              held_fn = fn;
              held_wt = wt;
              acc = '0;
              nbytes = '0;
              if (wt == pwfp_pkg::WT_VARINT) begin
                phase = pwfp_pkg::PH_VARINT;
              end else if (wt == pwfp_pkg::WT_LEN) begin
                phase = pwfp_pkg::PH_LENGTH;
              end else begin
                phase = pwfp_pkg::PH_FIXED;
                remaining = (wt == pwfp_pkg::WT_FIXED64) ? 64'd8 : 64'd4;
              end
            end
          end else if (last) begin
            push_result(pwfp_pkg::KIND_FIELD, '0, '0, '0, pwfp_pkg::ST_TRUNC, 1'b1);
          end
        end
      endcase
      if (last) restart();
    endfunction

    function string show(pwfp_pkg::res_t r);
      return $sformatf("kind=%0d field=%0d wtype=%0d value=%h status=%0d end=%0d",
                       r.kind, r.field_number, r.wtype, r.value, r.status,
                       r.message_end);
    endfunction

    function void compare_result(pwfp_pkg::res_t got);
      pwfp_pkg::res_t want;
      bit             bad;
      if (pending_fields.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result at %0t: %s", $realtime, show(got));
        end
        return;
      end
      want = pending_fields.pop_front();
      bad = (got.kind !== want.kind) || (got.field_number !== want.field_number) ||
            (got.wtype !== want.wtype) || (got.value !== want.value) ||
            (got.status !== want.status) || (got.message_end !== want.message_end);
      if (bad) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end else begin
        if (want.kind == pwfp_pkg::KIND_PAYLOAD) payload_results++;
        else field_results++;
        status_count[want.status]++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pwfp_in_if  in_if ();
  pwfp_out_if out_if ();

  protobuf_wire_field_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  field_result_board board;
  logic [7:0]        msg_bytes[$];
  bit                stalls_enabled = 1'b1;
  int unsigned       messages_sent = 0;
  pwfp_pkg::res_t    seen;

  always #CLK_HALF clk = ~clk;

  // both channels are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) board.take_byte(in_if.data_byte, in_if.last_byte);
      if (out_if.valid && out_if.ready) begin
        seen.kind = out_if.kind;
        seen.field_number = out_if.field_number;
        seen.wtype = out_if.wtype;
        seen.value = out_if.value;
        seen.status = pwfp_pkg::status_t'(out_if.status);
        seen.message_end = out_if.message_end;
        board.compare_result(seen);
      end
    end
  end

  // result side back-pressure: ready low about a fifth of the time
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= stalls_enabled ? ($urandom_range(99) >= 21) : 1'b1;
    end
  end

  // ends the run when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)))
        quiet = 0;
      else
        quiet++;
    end
    $display("no handshake for %0d cycles, %0d results still pending", STALL_LIMIT,
             board.pending_fields.size());
    $display("CHECK FAILED");
    $finish;
  end

  // one request; random idle cycles first, then hold until ready
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (stalls_enabled && $urandom_range(99) < 21) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // last byte mark goes on the final byte of the queued message
  task automatic send_message();
    int unsigned i;
    for (i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    messages_sent++;
  endtask

  // optional non-minimal form: one extra continuation byte and a zero group
  function automatic void put_varint(input logic [63:0] v, input bit pad);
    int unsigned n;
    n = 0;
    while (v > 64'd127) begin
      msg_bytes.push_back({1'b1, v[6:0]});
      v = v >> 7;
      n++;
    end
    if (pad && n < 8) begin
      msg_bytes.push_back({1'b1, v[6:0]});
      msg_bytes.push_back(8'h00);
    end else begin
      msg_bytes.push_back({1'b0, v[6:0]});
    end
  endfunction

  // values of random widths, with zero and all ones mixed in
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int unsigned width;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      default: begin
        width = $urandom_range(1, 64);
        if (width < 64) v = v & ((64'd1 << width) - 64'd1);
      end
    endcase
    return v;
  endfunction

  // wide numbers check the truncation of the tag to 32 field bits
  function automatic logic [60:0] random_field_number();
    case ($urandom_range(9))
      6, 7:    return 61'($urandom_range(32, 65535));
      8:       return 61'($urandom);
      9:       return {29'($urandom), 32'($urandom)};
      default: return 61'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic void add_field();
    logic [2:0]  wt;
    logic [63:0] len;
    case ($urandom_range(3))
      0:       wt = pwfp_pkg::WT_VARINT;
      1:       wt = pwfp_pkg::WT_FIXED64;
      2:       wt = pwfp_pkg::WT_LEN;
      default: wt = pwfp_pkg::WT_FIXED32;
    endcase
    put_varint({random_field_number(), wt}, $urandom_range(15) == 0);
    case (wt)
      pwfp_pkg::WT_VARINT:  put_varint(random_value(), $urandom_range(15) == 0);
      pwfp_pkg::WT_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
      pwfp_pkg::WT_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
      default: begin
        len = ($urandom_range(9) == 0) ? 64'($urandom_range(9, 40)) : 64'($urandom_range(0, 8));
        put_varint(len, $urandom_range(15) == 0);
        repeat (len) msg_bytes.push_back(8'($urandom));
      end
    endcase
  endfunction

  // well-formed messages dominate; cut, unknown, overlong and noise fill the rest
  function automatic void build_message();
    int unsigned mode;
    int unsigned keep;
    logic [2:0]  odd_wt;
    msg_bytes.delete();
    mode = $urandom_range(99);
    if (mode < 80) begin
      repeat ($urandom_range(1, 5)) add_field();
      if (mode >= 68) begin
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end
    end else if (mode < 87) begin
      repeat ($urandom_range(0, 2)) add_field();
      case ($urandom_range(3))
        0:       odd_wt = WT_SGROUP;
        1:       odd_wt = WT_EGROUP;
        2:       odd_wt = WT_BAD6;
        default: odd_wt = WT_BAD7;
      endcase
      put_varint({random_field_number(), odd_wt}, 1'b0);
      repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
    end else if (mode < 94) begin
      repeat ($urandom_range(0, 2)) add_field();
      // overlong in the tag itself, in a varint value or in a length
      case ($urandom_range(2))
        1:       put_varint({random_field_number(), pwfp_pkg::WT_VARINT}, 1'b0);
        2:       put_varint({random_field_number(), pwfp_pkg::WT_LEN}, 1'b0);
        default: ;
      endcase
      repeat (pwfp_pkg::MAX_VARINT_BYTES) msg_bytes.push_back({1'b1, 7'($urandom)});
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
    end
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    board = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // varint, fixed32, one payload byte, then a zero length closing the message
    msg_bytes = '{8'h08, 8'h96, 8'h01, 8'h1D, 8'h01, 8'h02, 8'h03, 8'h04,
                  8'h12, 8'h01, 8'h7F, 8'h1A, 8'h00};
    send_message();
    // fixed64 of all ones completing on the last byte
    msg_bytes = '{8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    // largest varint in ten bytes, under the largest field number
    msg_bytes.delete();
    put_varint(64'h7_FFFF_FFF8, 1'b0);
    put_varint('1, 1'b0);
    send_message();
    // overlong tag
    msg_bytes.delete();
    repeat (pwfp_pkg::MAX_VARINT_BYTES) msg_bytes.push_back(8'hFF);
    send_message();
    // overlong varint value, then a byte the halted parser ignores
    msg_bytes = '{8'h08};
    repeat (pwfp_pkg::MAX_VARINT_BYTES) msg_bytes.push_back(8'h80);
    msg_bytes.push_back(8'h00);
    send_message();
    // overlong length
    msg_bytes = '{8'h12};
    repeat (pwfp_pkg::MAX_VARINT_BYTES) msg_bytes.push_back(8'hFF);
    send_message();
    // unknown wire types, one followed by an ignored byte
    msg_bytes = '{8'h0B, 8'h00};
    send_message();
    msg_bytes = '{8'h0C};
    send_message();
    msg_bytes = '{8'h0E};
    send_message();
    msg_bytes = '{8'h0F};
    send_message();
    // messages cut inside tag, after tag, in value, fixed, length and payload
    msg_bytes = '{8'h80};
    send_message();
    msg_bytes = '{8'h08};
    send_message();
    msg_bytes = '{8'h08, 8'h80};
    send_message();
    msg_bytes = '{8'h0D, 8'h01};
    send_message();
    msg_bytes = '{8'h12, 8'h80};
    send_message();
    msg_bytes = '{8'h12, 8'h03};
    send_message();
    msg_bytes = '{8'h12, 8'h03, 8'h41};
    send_message();

    // random messages until enough bytes have been parsed
    while (board.parsed_bytes < RANDOM_BYTES) begin
      stalls_enabled = !(board.parsed_bytes >= BURST_START && board.parsed_bytes < BURST_END);
      build_message();
      send_message();
    end
    stalls_enabled = 1'b1;
    @(negedge clk);
    in_if.valid <= 1'b0;

    // drain, then allow for anything arriving late
    while (board.pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d messages, %0d bytes parsed; %0d field results, %0d payload bytes checked",
             messages_sent, board.parsed_bytes, board.field_results, board.payload_results);
    $display("statuses seen: ok %0d, truncated %0d, unknown type %0d, overlong %0d; failures %0d",
             board.status_count[pwfp_pkg::ST_OK], board.status_count[pwfp_pkg::ST_TRUNC],
             board.status_count[pwfp_pkg::ST_UNKNOWN], board.status_count[pwfp_pkg::ST_OVERLONG],
             board.failures);
    if (board.failures == 0 && board.pending_fields.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pwfp_pkg.sv
hw/rtl/pwfp_if.sv
hw/rtl/pwfp_core.sv
hw/rtl/protobuf_wire_field_parser.sv
test/protobuf_wire_field_parser_tb.sv
